[src/ycbcr_nps_pkg.sv]
// Shared constants, register codes and interface types of the nearest palette search block.
`default_nettype none
package ycbcr_nps_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  // signed query color, 14 fraction bits
  localparam int CW  = 27;
  // chroma product width
  localparam int PW  = 26;
  // distance magnitude, square and sum widths
  localparam int MW  = 26;
  localparam int SQW = 52;
  localparam int DW  = 54;

  localparam logic [15:0] COEF_R_CR_RST  = 16'd22970;
  localparam logic [15:0] COEF_G_CB_RST  = 16'd5638;
  localparam logic [15:0] COEF_G_CR_RST  = 16'd11701;
  localparam logic [15:0] COEF_B_CB_RST  = 16'd29032;
  localparam logic [7:0]  WHITE_LUMA_RST = 8'd240;

  localparam logic [2:0] REG_COEF_R_CR  = 3'd0;
  localparam logic [2:0] REG_COEF_G_CB  = 3'd1;
  localparam logic [2:0] REG_COEF_G_CR  = 3'd2;
  localparam logic [2:0] REG_COEF_B_CB  = 3'd3;
  localparam logic [2:0] REG_WHITE_LUMA = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // entry luma weights over 2^14
  localparam logic [13:0] LUMA_WR = 14'd4899;
  localparam logic [13:0] LUMA_WG = 14'd9617;
  localparam logic [13:0] LUMA_WB = 14'd1868;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic last;
  } walk_ctl_t;

  typedef struct packed {
    logic       done;
    logic       no_match;
    logic [7:0] best_index;
  } walk_res_t;

endpackage
`default_nettype wire

[src/ycbcr_nps_color.sv]
// Query color setup: YCbCr to fixed-point RGB in a product stage and a sum stage.
`default_nettype none
module ycbcr_nps_color (
  input  wire logic                                 clk,
  input  wire logic                                 start,
  input  wire logic                                 sum_en,
  input  wire logic [7:0]                           luma,
  input  wire logic [7:0]                           blue_diff,
  input  wire logic [7:0]                           red_diff,
  input  wire logic [15:0]                          coef_r_from_cr,
  input  wire logic [15:0]                          coef_g_from_cb,
  input  wire logic [15:0]                          coef_g_from_cr,
  input  wire logic [15:0]                          coef_b_from_cb,
  input  wire logic [7:0]                           white_luma,
  output logic signed [ycbcr_nps_pkg::CW-1:0]       q_r,
  output logic signed [ycbcr_nps_pkg::CW-1:0]       q_g,
  output logic signed [ycbcr_nps_pkg::CW-1:0]       q_b,
  output logic                                      white_hit
);

  logic signed [8:0]                     cb;
  logic signed [8:0]                     cr;
  logic signed [ycbcr_nps_pkg::PW-1:0]   p_r_cr;
  logic signed [ycbcr_nps_pkg::PW-1:0]   p_g_cb;
  logic signed [ycbcr_nps_pkg::PW-1:0]   p_g_cr;
  logic signed [ycbcr_nps_pkg::PW-1:0]   p_b_cb;
  logic [7:0]                            luma_q;
  logic signed [ycbcr_nps_pkg::CW-1:0]   y14;

  assign cb  = 9'($signed({1'b0, blue_diff}) - 9'sd128);
  assign cr  = 9'($signed({1'b0, red_diff}) - 9'sd128);
  assign y14 = $signed({5'b0, luma_q, 14'b0});

  always_ff @(posedge clk) begin
    if (start) begin
      p_r_cr <= $signed({1'b0, coef_r_from_cr}) * cr;
      p_g_cb <= $signed({1'b0, coef_g_from_cb}) * cb;
      p_g_cr <= $signed({1'b0, coef_g_from_cr}) * cr;
      p_b_cb <= $signed({1'b0, coef_b_from_cb}) * cb;
      luma_q <= luma;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      q_r       <= y14 + ycbcr_nps_pkg::CW'(p_r_cr);
      q_g       <= y14 - ycbcr_nps_pkg::CW'(p_g_cb) - ycbcr_nps_pkg::CW'(p_g_cr);
      q_b       <= y14 + ycbcr_nps_pkg::CW'(p_b_cb);
      white_hit <= (luma_q == white_luma);
    end
  end

endmodule
`default_nettype wire

[src/ycbcr_nps_dist.sv]
// Palette memory and the shared distance pipeline with running best-entry tracking.
`default_nettype none
module ycbcr_nps_dist #(
  parameter int PALETTE_ENTRIES = ycbcr_nps_pkg::PALETTE_ENTRIES_DEF,
  parameter int AW              = $clog2(PALETTE_ENTRIES)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  wr_en,
  input  wire logic [AW-1:0]                         wr_addr,
  input  wire logic [23:0]                           wr_data,
  input  wire ycbcr_nps_pkg::walk_ctl_t              ctl,
  input  wire logic [AW-1:0]                         rd_addr,
  input  wire logic signed [ycbcr_nps_pkg::CW-1:0]   q_r,
  input  wire logic signed [ycbcr_nps_pkg::CW-1:0]   q_g,
  input  wire logic signed [ycbcr_nps_pkg::CW-1:0]   q_b,
  input  wire logic                                  white_hit,
  input  wire logic [7:0]                            white_luma,
  output ycbcr_nps_pkg::walk_res_t                   res
);

  logic [23:0] mem [PALETTE_ENTRIES];

  // stage 1: memory read
  logic           s1_v, s1_last;
  logic [AW-1:0]  s1_idx;
  logic [23:0]    rd_data;
  // stage 2: magnitudes and white rule
  logic           s2_v, s2_last, s2_skip;
  logic [AW-1:0]  s2_idx;
  logic [ycbcr_nps_pkg::MW-1:0] s2_mr, s2_mg, s2_mb;
  // stage 3: squares
  logic           s3_v, s3_last, s3_skip;
  logic [AW-1:0]  s3_idx;
  logic [ycbcr_nps_pkg::SQW-1:0] s3_sr, s3_sg, s3_sb;
  // stage 4: sum
  logic           s4_v, s4_last, s4_skip;
  logic [AW-1:0]  s4_idx;
  logic [ycbcr_nps_pkg::DW-1:0] s4_sum;
  // running best
  logic           found, done;
  logic [AW-1:0]  best;
  logic [ycbcr_nps_pkg::DW-1:0] best_dist;

  logic signed [ycbcr_nps_pkg::CW-1:0] e_r14, e_g14, e_b14;
  logic signed [ycbcr_nps_pkg::CW-1:0] d_r, d_g, d_b;
  logic [21:0] lsum;
  logic [7:0]  elum;
  logic        take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign e_r14 = $signed({5'b0, rd_data[23:16], 14'b0});
  assign e_g14 = $signed({5'b0, rd_data[15:8], 14'b0});
  assign e_b14 = $signed({5'b0, rd_data[7:0], 14'b0});
  assign d_r   = e_r14 - q_r;
  assign d_g   = e_g14 - q_g;
  assign d_b   = e_b14 - q_b;
  assign lsum  = ycbcr_nps_pkg::LUMA_WG * 22'(rd_data[15:8])
               + ycbcr_nps_pkg::LUMA_WB * 22'(rd_data[7:0])
               + ycbcr_nps_pkg::LUMA_WR * 22'(rd_data[23:16]);
  assign elum  = lsum[21:14];
  assign take  = s4_v && !s4_skip && (!found || (s4_sum < best_dist));

  always_ff @(posedge clk) begin
    s1_idx  <= rd_addr;
    s2_idx  <= s1_idx;
    s2_mr   <= ycbcr_nps_pkg::MW'(d_r[ycbcr_nps_pkg::CW-1] ? -d_r : d_r);
    s2_mg   <= ycbcr_nps_pkg::MW'(d_g[ycbcr_nps_pkg::CW-1] ? -d_g : d_g);
    s2_mb   <= ycbcr_nps_pkg::MW'(d_b[ycbcr_nps_pkg::CW-1] ? -d_b : d_b);
    s2_skip <= white_hit && (elum < white_luma);
    s3_idx  <= s2_idx;
    s3_skip <= s2_skip;
    s3_sr   <= s2_mr * s2_mr;
    s3_sg   <= s2_mg * s2_mg;
    s3_sb   <= s2_mb * s2_mb;
    s4_idx  <= s3_idx;
    s4_skip <= s3_skip;
    s4_sum  <= ycbcr_nps_pkg::DW'(s3_sr) + ycbcr_nps_pkg::DW'(s3_sg)
             + ycbcr_nps_pkg::DW'(s3_sb);
    if (take) begin
      best      <= s4_idx;
      best_dist <= s4_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0; s1_last <= 1'b0;
      s2_v <= 1'b0; s2_last <= 1'b0;
      s3_v <= 1'b0; s3_last <= 1'b0;
      s4_v <= 1'b0; s4_last <= 1'b0;
      found <= 1'b0;
      done  <= 1'b0;
    end else begin
      s1_v    <= ctl.rd_en;
      s1_last <= ctl.rd_en && ctl.last;
      s2_v    <= s1_v;
      s2_last <= s1_last;
      s3_v    <= s2_v;
      s3_last <= s2_last;
      s4_v    <= s3_v;
      s4_last <= s3_last;
      done    <= s4_v && s4_last;
      if (ctl.clear) begin
        found <= 1'b0;
      end else if (take) begin
        found <= 1'b1;
      end
    end
  end

  assign res.done       = done;
  assign res.no_match   = !found;
  assign res.best_index = found ? 8'(best) : 8'd0;

endmodule
`default_nettype wire

[src/ycbcr_nearest_palette_search_unit.sv]
// Nearest palette color search for YCbCr queries: request sequencer, registers, output stage.
//
// Usage:
//   s_axis carries requests. tuser = 0 writes palette slot entry_index with entry_rgb
//   (slots at or beyond PALETTE_ENTRIES are ignored); tuser = 1 is a query on luma,
//   blue_diff and red_diff. Every slot must be written before the first query.
//   m_axis returns one result per query: best_index and no_match. Writes give no result.
//   cfg_we/cfg_index/cfg_data set the four Q2.14 coefficients and the white luma; write
//   them only while no query is in flight.
// Timing:
//   Writes may follow back to back.
//   A query runs from acceptance to result through the chroma products, the color sums,
//   one palette read per cycle through the single read port, the distance pipeline and
//   the result hand-off. s_axis is not ready during that time.
// Reset and stall:
//   rst clears the sequencer, the output valid and reloads the register defaults; the
//   palette keeps whatever it held. A finished result waits in the output register; the
//   next request is accepted meanwhile, and a following query holds its result back
//   until the previous one is taken.
`default_nettype none
module ycbcr_nearest_palette_search_unit #(
  parameter int PALETTE_ENTRIES = ycbcr_nps_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index[7:0], entry_rgb[31:8], luma[39:32], blue_diff[47:40], red_diff[55:48]
  input  wire logic [55:0] s_axis_tdata,
  // opcode[0]
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // best_index[7:0], no_match[8]
  output logic [15:0]      m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_WALK  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  logic [2:0]    state, state_next;
  logic [AW-1:0] addr;
  logic [15:0]   coef_r_from_cr, coef_g_from_cb, coef_g_from_cr, coef_b_from_cb;
  logic [7:0]    white_luma;

  logic accept, query_go, wr_go, out_free, out_load;
  logic signed [ycbcr_nps_pkg::CW-1:0] q_r, q_g, q_b;
  logic white_hit;
  ycbcr_nps_pkg::walk_ctl_t ctl;
  ycbcr_nps_pkg::walk_res_t res;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign query_go = accept && (s_axis_tuser == ycbcr_nps_pkg::OP_QUERY);
  assign wr_go    = accept && (s_axis_tuser == ycbcr_nps_pkg::OP_WRITE)
                  && ({1'b0, s_axis_tdata[7:0]} < 9'(PALETTE_ENTRIES));
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = (state == ST_HOLD) && out_free;

  assign ctl.clear = (state == ST_SUM);
  assign ctl.rd_en = (state == ST_WALK);
  assign ctl.last  = (addr == AW'(PALETTE_ENTRIES - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (query_go) state_next = ST_SUM;
      ST_SUM:   state_next = ST_WALK;
      ST_WALK:  if (ctl.last) state_next = ST_DRAIN;
      ST_DRAIN: if (res.done) state_next = ST_HOLD;
      ST_HOLD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      addr           <= '0;
      m_axis_tvalid  <= 1'b0;
      coef_r_from_cr <= ycbcr_nps_pkg::COEF_R_CR_RST;
      coef_g_from_cb <= ycbcr_nps_pkg::COEF_G_CB_RST;
      coef_g_from_cr <= ycbcr_nps_pkg::COEF_G_CR_RST;
      coef_b_from_cb <= ycbcr_nps_pkg::COEF_B_CB_RST;
      white_luma     <= ycbcr_nps_pkg::WHITE_LUMA_RST;
    end else begin
      state <= state_next;
      if (state == ST_SUM) begin
        addr <= '0;
      end else if (state == ST_WALK) begin
        addr <= addr + 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          ycbcr_nps_pkg::REG_COEF_R_CR:  coef_r_from_cr <= cfg_data;
          ycbcr_nps_pkg::REG_COEF_G_CB:  coef_g_from_cb <= cfg_data;
          ycbcr_nps_pkg::REG_COEF_G_CR:  coef_g_from_cr <= cfg_data;
          ycbcr_nps_pkg::REG_COEF_B_CB:  coef_b_from_cb <= cfg_data;
          ycbcr_nps_pkg::REG_WHITE_LUMA: white_luma     <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {7'b0, res.no_match, res.best_index};
    end
  end

  ycbcr_nps_color u_color (
    .clk            (clk),
    .start          (query_go),
    .sum_en         (state == ST_SUM),
    .luma           (s_axis_tdata[39:32]),
    .blue_diff      (s_axis_tdata[47:40]),
    .red_diff       (s_axis_tdata[55:48]),
    .coef_r_from_cr (coef_r_from_cr),
    .coef_g_from_cb (coef_g_from_cb),
    .coef_g_from_cr (coef_g_from_cr),
    .coef_b_from_cb (coef_b_from_cb),
    .white_luma     (white_luma),
    .q_r            (q_r),
    .q_g            (q_g),
    .q_b            (q_b),
    .white_hit      (white_hit)
  );

  ycbcr_nps_dist #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .AW              (AW)
  ) u_dist (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_go),
    .wr_addr    (s_axis_tdata[AW-1:0]),
    .wr_data    (s_axis_tdata[31:8]),
    .ctl        (ctl),
    .rd_addr    (addr),
    .q_r        (q_r),
    .q_g        (q_g),
    .q_b        (q_b),
    .white_hit  (white_hit),
    .white_luma (white_luma),
    .res        (res)
  );

endmodule
`default_nettype wire

[src/ycbcr_nps_checker.sv]
// Port-level checks of the nearest palette search unit, bound to the top level.
`default_nettype none
module ycbcr_nps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);

  // a query keeps the input side closed in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ycbcr_nps_pkg::OP_QUERY)
    |=> !s_axis_tready)
    else $error("input ready right after a query");

  a_no_match_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[8] |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("no_match with nonzero index");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'd0))
    else $error("result padding not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind ycbcr_nearest_palette_search_unit ycbcr_nps_checker u_nps_checker (.*);
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the YCbCr nearest palette search unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ycbcr_nps_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 1500;
  localparam int SETTLE       = 10;

  typedef struct packed {
    logic       no_match;
    logic [7:0] best_index;
  } pick_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  slot;
    logic [23:0] rgb;
    logic [7:0]  y;
    logic [7:0]  cb;
    logic [7:0]  cr;
    logic        typed;
    pick_t       pick;
  } plan_row_t;

  // pick is {no_match, best_index}; typed rows carry their answer, the rest are predicted
  localparam plan_row_t PLAN [22] = '{
    '{OP_QUERY,  8'd0,   24'h000000, 8'd0,   8'd128, 8'd128, 1'b1, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd240, 8'd128, 8'd128, 1'b1, '{1'b1, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd255, 8'd255, 8'd255, 1'b1, '{1'b0, 8'd0}},
    '{OP_WRITE,  8'd255, 24'hFFFFFF, 8'd0,   8'd0,   8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd240, 8'd128, 8'd128, 1'b1, '{1'b0, 8'd255}},
    '{OP_WRITE,  8'd7,   24'hFFFFFF, 8'd0,   8'd0,   8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd240, 8'd128, 8'd128, 1'b1, '{1'b0, 8'd7}},
    '{OP_WRITE,  8'd100, 24'hF0F0F0, 8'd0,   8'd0,   8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd240, 8'd128, 8'd128, 1'b1, '{1'b0, 8'd100}},
    '{OP_WRITE,  8'd101, 24'hEFEFEF, 8'd0,   8'd0,   8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd239, 8'd128, 8'd128, 1'b1, '{1'b0, 8'd101}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd240, 8'd0,   8'd255, 1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd0,   8'd0,   8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd255, 8'd255, 8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_WRITE,  8'd0,   24'hFF0000, 8'd0,   8'd0,   8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_WRITE,  8'd128, 24'h00FF00, 8'd255, 8'd255, 8'd255, 1'b0, '{1'b0, 8'd0}},
    '{OP_WRITE,  8'd200, 24'h0000FF, 8'd0,   8'd0,   8'd0,   1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd76,  8'd85,  8'd255, 1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd150, 8'd44,  8'd21,  1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd29,  8'd255, 8'd107, 1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd0,   24'h000000, 8'd128, 8'd128, 8'd128, 1'b0, '{1'b0, 8'd0}},
    '{OP_QUERY,  8'd255, 24'hFFFFFF, 8'd255, 8'd0,   8'd255, 1'b0, '{1'b0, 8'd0}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // entry_index[7:0], entry_rgb[31:8], luma[39:32], blue_diff[47:40], red_diff[55:48]
  logic [55:0] s_axis_tdata = '0;
  // opcode[0]
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // best_index[7:0], no_match[8]
  logic [15:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // mirror of the block's palette and registers
  logic [23:0] palette_copy [256];
  logic [15:0] gain_r_cr = COEF_R_CR_RST;
  logic [15:0] gain_g_cb = COEF_G_CB_RST;
  logic [15:0] gain_g_cr = COEF_G_CR_RST;
  logic [15:0] gain_b_cb = COEF_B_CB_RST;
  logic [7:0]  white_level = WHITE_LUMA_RST;

  pick_t pending_picks [$];
  pick_t want;
  int    mismatches = 0;
  int    idle_pct = 18;
  int    quiet_cycles = 0;
  int    hold_left = 0;
  bit    hold_arm = 1'b0;

  ycbcr_nearest_palette_search_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic pick_t nearest_entry(input logic [7:0] y, input logic [7:0] cb_raw,
                                          input logic [7:0] cr_raw);
    longint     cb, cr, qr, qg, qb, dr, dg, db, sq_total, best_dist;
    int         lum;
    logic [7:0] er, eg, eb;
    bit         found;
    pick_t      pick;
    cb = longint'(cb_raw) - 128;
    cr = longint'(cr_raw) - 128;
    qr = longint'(y) * 16384 + longint'(gain_r_cr) * cr;
    qg = longint'(y) * 16384 - longint'(gain_g_cb) * cb - longint'(gain_g_cr) * cr;
    qb = longint'(y) * 16384 + longint'(gain_b_cb) * cb;
    found = 1'b0;
    best_dist = 0;
    pick = '0;
    for (int i = 0; i < 256; i++) begin
      er = palette_copy[i][23:16];
      eg = palette_copy[i][15:8];
      eb = palette_copy[i][7:0];
      lum = (int'(LUMA_WG) * int'(eg) + int'(LUMA_WB) * int'(eb)
             + int'(LUMA_WR) * int'(er)) >> 14;
      if (y == white_level && lum < int'(white_level)) continue;
      dr = longint'(er) * 16384 - qr;
      dg = longint'(eg) * 16384 - qg;
      db = longint'(eb) * 16384 - qb;
      sq_total = dr * dr + dg * dg + db * db;
      if (!found || sq_total < best_dist) begin
        found = 1'b1;
        best_dist = sq_total;
        pick.best_index = 8'(i);
      end
    end
    pick.no_match = !found;
    return pick;
  endfunction

  task automatic push_request(input logic op, input logic [7:0] slot, input logic [23:0] rgb,
                              input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                              input logic typed, input pick_t typed_pick);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {cr, cb, y, rgb, slot};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (op == OP_WRITE) palette_copy[slot] = rgb;
    else if (typed) pending_picks.push_back(typed_pick);
    else pending_picks.push_back(nearest_entry(y, cb, cr));
  endtask

  task automatic load_settings(input logic [15:0] r_cr, input logic [15:0] g_cb,
                               input logic [15:0] g_cr, input logic [15:0] b_cb,
                               input logic [7:0] white);
    s_axis_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_COEF_R_CR;
    cfg_data <= r_cr;
    @(posedge clk);
    cfg_index <= REG_COEF_G_CB;
    cfg_data <= g_cb;
    @(posedge clk);
    cfg_index <= REG_COEF_G_CR;
    cfg_data <= g_cr;
    @(posedge clk);
    cfg_index <= REG_COEF_B_CB;
    cfg_data <= b_cb;
    @(posedge clk);
    cfg_index <= REG_WHITE_LUMA;
    cfg_data <= {8'd0, white};
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_r_cr = r_cr;
    gain_g_cb = g_cb;
    gain_g_cr = g_cr;
    gain_b_cb = b_cb;
    white_level = white;
  endtask

  task automatic random_traffic(input int count);
    logic [7:0]  y, cb, cr;
    logic [23:0] rgb;
    logic        op;
    for (int n = 0; n < count; n++) begin
      y = 8'($urandom);
      cb = 8'($urandom);
      cr = 8'($urandom);
      rgb = 24'($urandom);
      case ($urandom_range(0, 9))
        0: rgb = 24'hFFFFFF;
        1: rgb = {3{white_level}} ^ 24'($urandom_range(0, 7));
        2: rgb = {3{white_level - 8'd1}};
        default: ;
      endcase
      // queries sitting on the white threshold exercise the exclusion rule
      if ($urandom_range(0, 9) < 3) y = white_level;
      if ($urandom_range(0, 9) == 0) cb = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      if ($urandom_range(0, 9) == 0) cr = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      op = ($urandom_range(0, 99) < 40) ? OP_QUERY : OP_WRITE;
      push_request(op, 8'($urandom), rgb, y, cb, cr, 1'b0, '0);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // every slot must hold a color before the first query
    for (int k = 0; k < 256; k++)
      push_request(OP_WRITE, 8'(k), 24'h000000, 8'($urandom), 8'($urandom), 8'($urandom),
                   1'b0, '0);
    foreach (PLAN[i])
      push_request(PLAN[i].op, PLAN[i].slot, PLAN[i].rgb, PLAN[i].y, PLAN[i].cb, PLAN[i].cr,
                   PLAN[i].typed, PLAN[i].pick);
    hold_arm = 1'b1;
    random_traffic(450);
    idle_pct = 0;
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
    random_traffic(300);
    idle_pct = 18;
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    random_traffic(300);
    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    random_traffic(350);
    load_settings(COEF_R_CR_RST, COEF_G_CB_RST, COEF_G_CR_RST, COEF_B_CB_RST, WHITE_LUMA_RST);
    random_traffic(275);
    s_axis_tvalid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off so the request side backs up
  initial begin
    forever begin
      @(posedge clk);
      if (hold_arm && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_arm = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (int'($urandom_range(0, 99)) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_picks.size() == 0) begin
        $display("%0t: unexpected result best_index %0d no_match %0b", $time,
                 m_axis_tdata[7:0], m_axis_tdata[8]);
        mismatches++;
      end else begin
        want = pending_picks.pop_front();
        if (m_axis_tdata[7:0] !== want.best_index) begin
          $display("%0t: best_index expected %0d actual %0d", $time, want.best_index,
                   m_axis_tdata[7:0]);
          mismatches++;
        end
        if (m_axis_tdata[8] !== want.no_match) begin
          $display("%0t: no_match expected %0b actual %0b", $time, want.no_match,
                   m_axis_tdata[8]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
